FILE: design/assert_macros.svh
// Assertion macros used by the page table manager top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/tlptm_pkg.sv
// Package: types and constants of the page table manager
package tlptm_pkg;
   localparam logic [2:0] FUNC_ALLOC = 3'd0;
   localparam logic [2:0] FUNC_FREE  = 3'd1;
   localparam logic [2:0] FUNC_MAP   = 3'd2;
   localparam logic [2:0] FUNC_UNMAP = 3'd3;
   localparam logic [2:0] FUNC_FAULT = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_FRAMES = 3'd1;
   localparam logic [2:0] ST_NULL      = 3'd2;
   localparam logic [2:0] ST_KERNEL    = 3'd3;
   localparam logic [2:0] ST_NO_SLOT   = 3'd4;
   localparam logic [2:0] ST_STACK     = 3'd5;

   localparam logic [0:0] CSR_POOL_START = 1'd0;
   localparam logic [0:0] CSR_POOL_END   = 1'd1;

   localparam logic [31:0] FRAME_MASK = 32'hffff_f000;
   localparam logic [31:0] DIR_FLAGS  = 32'd7;
   localparam logic [31:0] NULL_LIMIT = 32'h0000_1000;
   localparam logic [31:0] USER_BASE  = 32'h8000_0000;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CHECK, S_POP, S_TAKE2, S_TABLE, S_WRITE, S_DONE
   } state_type;
endpackage

FILE: design/tlptm_frame_alloc.sv
// Frame allocator: free stack memory, fill count and bump pointer
module tlptm_frame_alloc #(
   parameter int FREE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cfg_start_we,
   input  logic [19:0] cfg_start,
   input  logic [19:0] pool_end,
   input  logic        push,
   input  logic [19:0] push_frame,
   input  logic        pop,
   output logic [19:0] pop_frame,
   output logic [20:0] avail,
   output logic        stack_full
);
   localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int CW = $clog2(FREE_DEPTH + 1);

   logic [19:0] stack_mem [FREE_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [19:0]   bump_ff, bump_in;
   logic [19:0]   rd_ff;
   logic [AW-1:0] top_idx;
   logic [20:0]   room;

   // address of the top entry (count minus one)
   assign top_idx = AW'(count_ff - CW'(1));
   assign room = (pool_end > bump_ff) ? 21'(pool_end - bump_ff) : 21'd0;
   assign avail = room + 21'(count_ff);
   assign stack_full = (32'(count_ff) >= 32'(FREE_DEPTH));

   // registered read of the top entry
   always_ff @(posedge clock) begin
      rd_ff <= stack_mem[top_idx];
      if (push) stack_mem[AW'(count_ff)] <= push_frame;
   end

   // pop from the stack first, else bump
   assign pop_frame = (count_ff != '0) ? rd_ff : bump_ff;

   always_comb begin
      count_in = count_ff;
      bump_in  = bump_ff;
      if (cfg_start_we) bump_in = cfg_start;
      else if (pop) begin
         if (count_ff != '0) count_in = count_ff - CW'(1);
         else bump_in = bump_ff + 20'd1;
      end else if (push) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bump_ff  <= 20'd256;
      end else begin
         count_ff <= count_in;
         bump_ff  <= bump_in;
      end
   end
endmodule

FILE: design/two_level_page_table_manager.sv
// Top level: two-level page table manager with frame pool
//
// One request at a time: busy rises after start, and the result strobes once. The
// states run READ, CHECK and DONE for free, unknown codes and every error. Alloc adds
// POP, and map or unmap into a present table adds WRITE. Map or unmap that allocates a
// table adds TABLE and WRITE, and a fault into a present table adds POP and WRITE. A
// fault that also allocates a table adds POP, TAKE2, TABLE and WRITE. The sequence is
// set by the one-port directory and table memories and the allocator's registered
// stack read. Busy falls in the strobe cycle, so the next start is taken at the edge
// that ends it. The receiver cannot stall; take the rsp_ word on the cycle rsp_valid
// is high. After reset a clearing pass holds busy until all TABLE_SLOTS * 1024 table
// entries are cleared (16384 by default). It writes one table entry a cycle and clears
// the directory alongside the first 1024 table entries.
`include "assert_macros.svh"
module two_level_page_table_manager #(
   parameter int TABLE_SLOTS = 16,
   parameter int FREE_DEPTH  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic        req_user_access,
   input  logic        req_write_access,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_frame_addr,
   output logic [31:0] rsp_entry_value,
   output logic [31:0] rsp_dir_value,
   output logic        rsp_invalidate,
   output logic        rsp_table_allocated,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [19:0] csr_wdata
);
   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int UW = $clog2(TABLE_SLOTS + 1);
   localparam int TD = TABLE_SLOTS * 1024;
   localparam int TW = SW + 10;
   localparam int CLW = $clog2(TD + 1);

   tlptm_pkg::state_type state_ff, state_in;

   logic [31:0] dir_mem [1024];
   logic [SW-1:0] slot_mem [1024];
   logic [31:0] tbl_mem [TD];

   logic [19:0] start_ff, end_ff;
   logic [2:0]  func_ff;
   logic [31:0] va_ff, pa_ff;
   logic        user_ff, wr_ff;
   logic [31:0] dir_rd_ff;
   logic [SW-1:0] slot_rd_ff;
   logic [UW-1:0] used_ff, used_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] frame_ff, frame_in, entry_ff, entry_in, dirv_ff, dirv_in;
   logic        inv_ff, inv_in, talloc_ff, talloc_in, valid_ff, valid_in;
   logic [31:0] dir_new_ff, dir_new_in;
   logic [SW-1:0] slot_new_ff, slot_new_in;
   logic        need_tbl_ff, need_tbl_in;

   logic [9:0]  dir_idx;
   logic        dir_we, tbl_we, push, pop, stack_full;
   logic [19:0] pop_frame;
   logic [20:0] avail;
   logic [TW-1:0] tbl_addr;
   logic        clr_done;
   logic        clearing;
   logic        need_tbl;
   logic [1:0]  need;

   assign dir_idx  = va_ff[31:22];
   assign clr_done = (32'(clr_ff) >= 32'(TD));
   assign clearing = (state_ff == tlptm_pkg::S_IDLE) && !clr_done;
   assign need_tbl = !dir_rd_ff[0];
   assign need = 2'(func_ff == tlptm_pkg::FUNC_FAULT) + 2'(need_tbl);

   // hold the two pool registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 20'd256;
         end_ff   <= 20'd4096;
      end else if (csr_we) begin
         if (csr_index == tlptm_pkg::CSR_POOL_START) start_ff <= csr_wdata;
         else end_ff <= csr_wdata;
      end
   end

   tlptm_frame_alloc #(.FREE_DEPTH(FREE_DEPTH)) u_alloc (
      .clock(clock), .reset(reset),
      .cfg_start_we(csr_we && csr_index == tlptm_pkg::CSR_POOL_START),
      .cfg_start(csr_wdata), .pool_end(end_ff),
      .push(push), .push_frame(pa_ff[31:12]),
      .pop(pop), .pop_frame(pop_frame),
      .avail(avail), .stack_full(stack_full)
   );

   // directory and slot memories; only the directory is cleared after reset
   always_ff @(posedge clock) begin
      if (clearing) begin
         if (32'(clr_ff) < 32'd1024) dir_mem[clr_ff[9:0]] <= '0;
      end else if (dir_we) begin
         dir_mem[dir_idx]  <= dir_new_ff;
         slot_mem[dir_idx] <= slot_new_ff;
      end
      dir_rd_ff  <= dir_mem[dir_idx];
      slot_rd_ff <= slot_mem[dir_idx];
   end

   // table memory: clear every entry after reset, then at most one write per request
   assign tbl_addr = need_tbl_ff ? {slot_new_ff, va_ff[21:12]}
                                 : {slot_rd_ff, va_ff[21:12]};
   always_ff @(posedge clock) begin
      if (clearing) tbl_mem[TW'(clr_ff)] <= '0;
      else if (tbl_we) tbl_mem[tbl_addr] <= entry_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlptm_pkg::S_IDLE:  if (clr_done && start) state_in = tlptm_pkg::S_READ;
         tlptm_pkg::S_READ:  state_in = tlptm_pkg::S_CHECK;
         tlptm_pkg::S_CHECK: begin
            unique case (func_ff) inside
               tlptm_pkg::FUNC_ALLOC: state_in = (avail == '0) ? tlptm_pkg::S_DONE
                                                               : tlptm_pkg::S_POP;
               tlptm_pkg::FUNC_MAP, tlptm_pkg::FUNC_UNMAP, tlptm_pkg::FUNC_FAULT:
                  if (func_ff == tlptm_pkg::FUNC_FAULT && va_ff < tlptm_pkg::USER_BASE)
                     state_in = tlptm_pkg::S_DONE;
                  else if (need_tbl && 32'(used_ff) >= 32'(TABLE_SLOTS))
                     state_in = tlptm_pkg::S_DONE;
                  else if (avail < 21'(need)) state_in = tlptm_pkg::S_DONE;
                  else if (func_ff == tlptm_pkg::FUNC_FAULT) state_in = tlptm_pkg::S_POP;
                  else if (need_tbl) state_in = tlptm_pkg::S_TABLE;
                  else state_in = tlptm_pkg::S_WRITE;
               default: state_in = tlptm_pkg::S_DONE;
            endcase
         end
         tlptm_pkg::S_POP: begin
            if (func_ff == tlptm_pkg::FUNC_ALLOC) state_in = tlptm_pkg::S_DONE;
            else if (need_tbl) state_in = tlptm_pkg::S_TAKE2;
            else state_in = tlptm_pkg::S_WRITE;
         end
         tlptm_pkg::S_TAKE2: state_in = tlptm_pkg::S_TABLE;
         tlptm_pkg::S_TABLE: state_in = tlptm_pkg::S_WRITE;
         tlptm_pkg::S_WRITE: state_in = tlptm_pkg::S_DONE;
         tlptm_pkg::S_DONE:  state_in = tlptm_pkg::S_IDLE;
         default:            state_in = tlptm_pkg::S_IDLE;
      endcase
   end

   // datapath and strobes
   always_comb begin
      status_in = status_ff; frame_in = frame_ff; entry_in = entry_ff;
      dirv_in = dirv_ff; inv_in = inv_ff; talloc_in = talloc_ff;
      dir_new_in = dir_new_ff; slot_new_in = slot_new_ff; need_tbl_in = need_tbl_ff;
      used_in = used_ff; valid_in = 1'b0;
      push = 1'b0; pop = 1'b0; dir_we = 1'b0; tbl_we = 1'b0;
      clr_in = clearing ? clr_ff + CLW'(1) : clr_ff;
      unique case (state_ff)
         tlptm_pkg::S_IDLE: begin
            status_in = tlptm_pkg::ST_OK; frame_in = '0; entry_in = '0; dirv_in = '0;
            inv_in = 1'b0; talloc_in = 1'b0; need_tbl_in = 1'b0;
         end
         tlptm_pkg::S_READ: ;
         tlptm_pkg::S_CHECK: begin
            unique case (func_ff) inside
               tlptm_pkg::FUNC_ALLOC:
                  if (avail == '0) status_in = tlptm_pkg::ST_NO_FRAMES;
               tlptm_pkg::FUNC_FREE:
                  if (stack_full) status_in = tlptm_pkg::ST_STACK;
                  else push = 1'b1;
               tlptm_pkg::FUNC_MAP, tlptm_pkg::FUNC_UNMAP, tlptm_pkg::FUNC_FAULT: begin
                  dirv_in = dir_rd_ff;
                  if (func_ff == tlptm_pkg::FUNC_FAULT && va_ff < tlptm_pkg::NULL_LIMIT)
                     status_in = tlptm_pkg::ST_NULL;
                  else if (func_ff == tlptm_pkg::FUNC_FAULT &&
                           va_ff < tlptm_pkg::USER_BASE)
                     status_in = tlptm_pkg::ST_KERNEL;
                  else if (need_tbl && 32'(used_ff) >= 32'(TABLE_SLOTS))
                     status_in = tlptm_pkg::ST_NO_SLOT;
                  else if (avail < 21'(need)) status_in = tlptm_pkg::ST_NO_FRAMES;
                  else if (func_ff == tlptm_pkg::FUNC_MAP)
                     entry_in = (pa_ff & tlptm_pkg::FRAME_MASK) |
                                {29'd0, user_ff, wr_ff, 1'b1};
               end
               default: ;
            endcase
         end
         tlptm_pkg::S_POP: begin
            pop = 1'b1;
            frame_in = {pop_frame, 12'd0};
            if (func_ff == tlptm_pkg::FUNC_FAULT)
               entry_in = {pop_frame, 12'd0} | tlptm_pkg::DIR_FLAGS;
         end
         tlptm_pkg::S_TAKE2: ;
         tlptm_pkg::S_TABLE: begin
            pop = 1'b1;
            dir_new_in = {pop_frame, 12'd0} | tlptm_pkg::DIR_FLAGS;
            slot_new_in = SW'(used_ff);
            need_tbl_in = 1'b1;
            used_in = used_ff + UW'(1);
            talloc_in = 1'b1;
         end
         tlptm_pkg::S_WRITE: begin
            tbl_we = 1'b1;
            dir_we = need_tbl_ff;
            if (need_tbl_ff) dirv_in = dir_new_ff;
            inv_in = 1'b1;
         end
         tlptm_pkg::S_DONE: valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlptm_pkg::S_IDLE;
         clr_ff <= '0;
         used_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tlptm_pkg::S_IDLE && start && !busy) begin
         func_ff <= req_func; va_ff <= req_virt_addr; pa_ff <= req_phys_addr;
         user_ff <= req_user_access; wr_ff <= req_write_access;
      end
      status_ff <= status_in; frame_ff <= frame_in; entry_ff <= entry_in;
      dirv_ff <= dirv_in; inv_ff <= inv_in; talloc_ff <= talloc_in;
      dir_new_ff <= dir_new_in; slot_new_ff <= slot_new_in; need_tbl_ff <= need_tbl_in;
   end

   assign busy = (state_ff != tlptm_pkg::S_IDLE) || !clr_done;
   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_frame_addr = frame_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_dir_value = dirv_ff;
   assign rsp_invalidate = inv_ff;
   assign rsp_table_allocated = talloc_ff;

   `ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLIES(a_inv_ok, clock, reset, rsp_valid && rsp_invalidate, rsp_status == 3'd0)
   `ASSERT_IMPLIES(a_slots, clock, reset, 1'b1, 32'(used_ff) <= 32'(TABLE_SLOTS))
endmodule

FILE: dv/two_level_page_table_manager_tb.sv
// Testbench: two-level page table manager driven by start/busy, checked against a predictor
`timescale 1ns / 1ps
module two_level_page_table_manager_tb;

   localparam int SLOT_COUNT  = 16;
   localparam int STACK_DEPTH = 1024;
   localparam int SETTLE      = 12;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] frame_addr;
      logic [31:0] entry_value;
      logic [31:0] dir_value;
      logic        invalidate;
      logic        table_allocated;
   } outcome_type;

   // Page table predictor and queue of pending outcomes
   class pt_scoreboard_type;
      logic [31:0] page_dir [1024];
      int          dir_slot [1024];
      logic [31:0] tables [SLOT_COUNT*1024];
      logic [19:0] free_stk [STACK_DEPTH];
      int          free_cnt;
      logic [19:0] bump;
      int          slots;
      logic [19:0] pool_start;
      logic [19:0] pool_end;
      outcome_type pending_q [$];
      int          errors;

      function new();
         foreach (page_dir[i]) page_dir[i] = '0;
         foreach (tables[i]) tables[i] = '0;
         free_cnt = 0;
         slots = 0;
         pool_start = 20'd256;
         pool_end = 20'd4096;
         bump = pool_start;
         errors = 0;
      endfunction

      function void set_reg(logic idx, logic [19:0] val);
         if (idx == tlptm_pkg::CSR_POOL_START) begin
            pool_start = val;
            bump = val;
         end else begin
            pool_end = val;
         end
      endfunction

      function int frames_left();
         int room;
         room = (pool_end > bump) ? int'(pool_end - bump) : 0;
         return free_cnt + room;
      endfunction

      function logic [19:0] take_frame();
         logic [19:0] f;
         if (free_cnt > 0) begin
            free_cnt--;
            return free_stk[free_cnt];
         end
         f = bump;
         bump = bump + 20'd1;
         return f;
      endfunction

      // Write one PTE, allocating a table where the directory entry is absent
      function logic [2:0] place_entry(logic [31:0] va, bit fault, logic [31:0] base,
                                       inout outcome_type o);
         int          d;
         bit          need_tab;
         int          need;
         logic [31:0] pte;
         logic [19:0] f;
         d = int'(va[31:22]);
         need_tab = !page_dir[d][0];
         need = int'(fault) + int'(need_tab);
         pte = base;
         if (need_tab && slots >= SLOT_COUNT) return tlptm_pkg::ST_NO_SLOT;
         if (frames_left() < need) return tlptm_pkg::ST_NO_FRAMES;
         if (fault) begin
            f = take_frame();
            o.frame_addr = {f, 12'h000};
            pte = {f, 12'h000} | 32'd7;
         end
         if (need_tab) begin
            f = take_frame();
            dir_slot[d] = slots;
            slots++;
            page_dir[d] = {f, 12'h000} | tlptm_pkg::DIR_FLAGS;
            o.table_allocated = 1'b1;
         end
         tables[dir_slot[d]*1024 + int'(va[21:12])] = pte;
         o.entry_value = pte;
         o.invalidate = 1'b1;
         return tlptm_pkg::ST_OK;
      endfunction

      function void note_request(logic [2:0] func, logic [31:0] va, logic [31:0] pa,
                                 logic usr, logic wr);
         outcome_type o;
         o = '{default: '0};
         o.status = tlptm_pkg::ST_OK;
         case (func)
            tlptm_pkg::FUNC_ALLOC: begin
               if (frames_left() == 0) o.status = tlptm_pkg::ST_NO_FRAMES;
               else o.frame_addr = {take_frame(), 12'h000};
            end
            tlptm_pkg::FUNC_FREE: begin
               if (free_cnt >= STACK_DEPTH) begin
                  o.status = tlptm_pkg::ST_STACK;
               end else begin
                  free_stk[free_cnt] = pa[31:12];
                  free_cnt++;
               end
            end
            tlptm_pkg::FUNC_MAP:
               o.status = place_entry(va, 1'b0,
                  (pa & tlptm_pkg::FRAME_MASK) | {29'd0, usr, wr, 1'b1}, o);
            tlptm_pkg::FUNC_UNMAP: o.status = place_entry(va, 1'b0, 32'd0, o);
            tlptm_pkg::FUNC_FAULT: begin
               if (va < tlptm_pkg::NULL_LIMIT) o.status = tlptm_pkg::ST_NULL;
               else if (va < tlptm_pkg::USER_BASE) o.status = tlptm_pkg::ST_KERNEL;
               else o.status = place_entry(va, 1'b1, 32'd0, o);
            end
            default: ;
         endcase
         if (func == tlptm_pkg::FUNC_MAP || func == tlptm_pkg::FUNC_UNMAP ||
             func == tlptm_pkg::FUNC_FAULT)
            o.dir_value = page_dir[va[31:22]];
         pending_q.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word, status %0d", $time, got.status);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.frame_addr !== e.frame_addr) begin
            $display("%0t: frame_addr exp %h got %h", $time, e.frame_addr, got.frame_addr);
            errors++;
         end
         if (got.entry_value !== e.entry_value) begin
            $display("%0t: entry_value exp %h got %h", $time, e.entry_value,
                     got.entry_value);
            errors++;
         end
         if (got.dir_value !== e.dir_value) begin
            $display("%0t: dir_value exp %h got %h", $time, e.dir_value, got.dir_value);
            errors++;
         end
         if (got.invalidate !== e.invalidate) begin
            $display("%0t: invalidate exp %b got %b", $time, e.invalidate, got.invalidate);
            errors++;
         end
         if (got.table_allocated !== e.table_allocated) begin
            $display("%0t: table_allocated exp %b got %b", $time, e.table_allocated,
                     got.table_allocated);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [31:0] req_virt_addr;
   logic [31:0] req_phys_addr;
   logic        req_user_access;
   logic        req_write_access;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_frame_addr;
   logic [31:0] rsp_entry_value;
   logic [31:0] rsp_dir_value;
   logic        rsp_invalidate;
   logic        rsp_table_allocated;
   logic        csr_we;
   logic        csr_index;
   logic [19:0] csr_wdata;

   pt_scoreboard_type sb;
   bit           no_idle;
   logic [9:0]   dir_pool [20];

   two_level_page_table_manager DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Take each result word on its strobe, away from the driving edge
   always @(negedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_status, rsp_frame_addr, rsp_entry_value, rsp_dir_value,
                           rsp_invalidate, rsp_table_allocated});
   end

   // Present one request word and hold it until the block accepts it
   task automatic send(logic [2:0] func, logic [31:0] va, logic [31:0] pa,
                       logic usr, logic wr);
      int  gap;
      bit  was_busy;
      if (!no_idle && $urandom_range(99) < 28) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_virt_addr <= va;
      req_phys_addr <= pa;
      req_user_access <= usr;
      req_write_access <= wr;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      sb.note_request(func, va, pa, usr, wr);
   endtask

   // Drop start and hold until every outcome is back and the block is quiet
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic set_pool(logic [19:0] first, logic [19:0] last);
      drain();
      write_reg(tlptm_pkg::CSR_POOL_START, first);
      write_reg(tlptm_pkg::CSR_POOL_END, last);
   endtask

   function automatic logic [31:0] pick_va(bit upper);
      logic [31:0] va;
      va = $urandom;
      if ($urandom_range(99) < 85) va[31:22] = dir_pool[$urandom_range(19)];
      if (upper) va[31] = 1'b1;
      return va;
   endfunction

   // Random request word with a weighted mix of operations
   task automatic send_random(int alloc_w, int free_w);
      int          r;
      logic [31:0] va;
      r = $urandom_range(99);
      if (r < alloc_w) begin
         send(tlptm_pkg::FUNC_ALLOC, $urandom, $urandom, 1'($urandom), 1'($urandom));
      end else if (r < alloc_w + free_w) begin
         send(tlptm_pkg::FUNC_FREE, $urandom, $urandom, 1'($urandom), 1'($urandom));
      end else if (r < 65) begin
         send(tlptm_pkg::FUNC_MAP, pick_va(1'b0), $urandom, 1'($urandom), 1'($urandom));
      end else if (r < 78) begin
         send(tlptm_pkg::FUNC_UNMAP, pick_va(1'b0), $urandom, 1'($urandom),
              1'($urandom));
      end else if (r < 96) begin
         va = pick_va($urandom_range(99) < 75);
         if ($urandom_range(99) < 8) va = $urandom_range(32'hfff);
         send(tlptm_pkg::FUNC_FAULT, va, $urandom, 1'($urandom), 1'($urandom));
      end else begin
         send(3'($urandom_range(5, 7)), $urandom, $urandom, 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      no_idle = 0;
      foreach (dir_pool[i])
         dir_pool[i] = (i < 10) ? 10'($urandom_range(511)) : 10'($urandom_range(512, 1023));
      reset = 1'b1;
      start = 1'b0;
      req_func = tlptm_pkg::FUNC_ALLOC;
      req_virt_addr = '0;
      req_phys_addr = '0;
      req_user_access = 1'b0;
      req_write_access = 1'b0;
      csr_we = 1'b0;
      csr_index = tlptm_pkg::CSR_POOL_START;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation, field extremes, fault regions, unknown codes
      send(tlptm_pkg::FUNC_ALLOC, 32'd0, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FREE, 32'd0, 32'hffff_ffff, 1'b1, 1'b1);
      send(tlptm_pkg::FUNC_FREE, 32'hffff_ffff, 32'h0000_0fff, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_ALLOC, 32'd0, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_MAP, 32'h0040_0000, 32'hffff_ffff, 1'b1, 1'b1);
      send(tlptm_pkg::FUNC_MAP, 32'h0040_1000, 32'h1234_5fff, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_MAP, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0);
      send(tlptm_pkg::FUNC_MAP, 32'h0000_0000, 32'hffff_f000, 1'b0, 1'b1);
      send(tlptm_pkg::FUNC_UNMAP, 32'h0040_0000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_UNMAP, 32'h7fc0_0000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'h0000_0000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'h0000_0fff, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'h0000_1000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'h7fff_ffff, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'hffff_f000, 32'd0, 1'b0, 1'b0);
      send(3'd5, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
      send(3'd6, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
      send(3'd7, 32'd0, 32'd0, 1'b1, 1'b0);

      // Tight pool: out of frames, fault needing two frames with one left
      set_pool(20'd100, 20'd103);
      send(tlptm_pkg::FUNC_FAULT, 32'hc000_0000, 32'd0, 1'b0, 1'b0);
      send(tlptm_pkg::FUNC_FAULT, 32'hc040_0000, 32'd0, 1'b0, 1'b0);
      repeat (250) send_random(10, 10);

      // Start beyond end: only freed frames can be handed out
      set_pool(20'hfffff, 20'd0);
      repeat (150) send_random(20, 15);

      // Top of the frame range
      set_pool(20'hffff0, 20'hfffff);
      repeat (250) send_random(15, 15);

      // Fill the free stack past its depth
      set_pool(20'd0, 20'd0);
      repeat (1060) begin
         if ($urandom_range(99) < 3) send_random(15, 15);
         else send(tlptm_pkg::FUNC_FREE, $urandom, $urandom, 1'($urandom), 1'($urandom));
      end

      // Wide pool, with a stretch of back-to-back requests
      set_pool(20'd0, 20'hfffff);
      no_idle = 1;
      repeat (200) send_random(12, 12);
      no_idle = 0;
      repeat (300) send_random(12, 12);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Guard against a hang
   initial begin
      #4ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

FILE: two_level_page_table_manager.f
+incdir+design
design/tlptm_pkg.sv
design/tlptm_frame_alloc.sv
design/two_level_page_table_manager.sv
dv/two_level_page_table_manager_tb.sv
